// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
// every use assumes a clock named clk and an active-low reset named rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in a cycle forces the consequent in the same cycle
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// antecedent in a cycle forces the consequent in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/wrp_pkg.sv -----
package wrp_pkg;

    // width of the random word, which is also the number of division steps
    localparam int RND_W = 32;
    localparam int INDEX_W = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_TOTAL = 2'd1,
        ST_OVERFLOW   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH
    } state_t;

    // status of the serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

// ----- sv/wrp_ram.sv -----
module wrp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/wrp_serial_mod.sv -----
`include "assert_macros.svh"

module wrp_serial_mod #(
    parameter int TOTAL_W = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [wrp_pkg::RND_W-1:0]   dividend,
    input  logic [TOTAL_W-1:0]          divisor,
    output logic [TOTAL_W-1:0]          remainder,
    output wrp_pkg::mod_stat_t          stat
);
    import wrp_pkg::*;

    localparam int STEP_W = $clog2(RND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RND_W - 1);

    logic [RND_W-1:0]   dvd_reg, dvd_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TOTAL_W:0]   shifted;
    logic [TOTAL_W:0]   diff;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, dvd_reg[RND_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[TOTAL_W-1:0];
            end
            else
            begin
                rem_next = shifted[TOTAL_W-1:0];
            end
            dvd_next  = {dvd_reg[RND_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_IMPLIES(a_rem_below_divisor, busy_reg, rem_reg < dsr_reg, "remainder not below divisor")
    `ASSERT_NEXT(a_done_single, done_reg, !done_reg && !busy_reg, "done not a single pulse")
    `ASSERT_IMPLIES(a_load_idle, load, !busy_reg, "load while busy")

endmodule

// ----- sv/weighted_random_pick.sv -----
// weighted random pick: a weight without the last mark is taken with no result
// last item, overflow or zero total: result strobe in the cycle after acceptance
// last item, ok: result after a bit-serial modulo of the random word by the total,
// a handoff and a registered search that reads one entry per cycle
// done pulses for one cycle and is not held; asynchronous active-low reset clears control
`include "assert_macros.svh"

module weighted_random_pick #(
    parameter int MAX_ENTRIES = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [15:0]                     weight,
    input  logic                            last_weight,
    input  logic [wrp_pkg::RND_W-1:0]       random_word,
    output logic                            done,
    output logic [wrp_pkg::INDEX_W-1:0]     chosen_index,
    output logic [wrp_pkg::STATUS_W-1:0]    pick_status
);
    import wrp_pkg::*;

    localparam int WB      = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_W = WB + $clog2(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               done_reg, done_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    status_t            status_reg, status_next;

    logic               accept;
    logic               room;
    logic [TOTAL_W-1:0] sum;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [TOTAL_W-1:0] rd_data;
    logic               mod_load;
    logic [TOTAL_W-1:0] rem;
    mod_stat_t          mod_stat;
    logic [IDX_W+INDEX_W-1:0] idx_ext;
    logic               ok_done;

    assign accept = start && !busy;
    assign room   = (count_reg < MAX_CNT);
    assign sum    = total_reg + TOTAL_W'(weight[WB-1:0]);
    assign wr_en  = accept && room;

    // prefix sums, one entry per stored weight
    wrp_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_prefix (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (sum),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // random word mod total, one bit per cycle
    wrp_serial_mod #(
        .TOTAL_W (TOTAL_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (mod_load),
        .dividend  (random_word),
        .divisor   (total_next),
        .remainder (rem),
        .stat      (mod_stat)
    );

    // next state, accumulation and search
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        scan_next       = scan_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        done_next       = 1'b0;
        idx_next        = idx_reg;
        status_next     = status_reg;
        mod_load        = 1'b0;
        rd_addr         = scan_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        total_next = sum;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_weight)
                    begin
                        priority if (ovf_next)
                        begin
                            done_next   = 1'b1;
                            idx_next    = '0;
                            status_next = ST_OVERFLOW;
                        end
                        else if (total_next == '0)
                        begin
                            done_next   = 1'b1;
                            idx_next    = '0;
                            status_next = ST_ZERO_TOTAL;
                        end
                        else
                        begin
                            mod_load   = 1'b1;
                            state_next = S_DIV;
                        end
                        // the set is closed: the store keeps its sums for the search
                        count_next = '0;
                        total_next = total_next;
                        ovf_next   = 1'b0;
                    end
                end
            end
            S_DIV:
            begin
                if (mod_stat.done)
                begin
                    scan_next       = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // read one entry a cycle, compare the one read last cycle
                scan_next       = scan_reg + IDX_W'(1);
                pend_idx_next   = scan_reg;
                pend_valid_next = 1'b1;
                if (pend_valid_reg && (rd_data > rem))
                begin
                    done_next       = 1'b1;
                    idx_next        = pend_idx_reg;
                    status_next     = ST_OK;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= (accept && last_weight) ? '0 : count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
            total_reg      <= (accept && last_weight) ? '0 : total_next;
        end
    end

    // search pointers and result payload
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
    end

    assign idx_ext      = {{INDEX_W{1'b0}}, idx_reg};
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign chosen_index = idx_ext[INDEX_W-1:0];
    assign pick_status  = status_reg;

    // strobe carrying a found index
    assign ok_done = done_reg && (status_reg == ST_OK);

    `ASSERT_ALWAYS(a_count_bound, count_reg <= MAX_CNT, "entry count beyond store depth")
    `ASSERT_IMPLIES(a_mod_done_in_div, mod_stat.done, state_reg == S_DIV, "mod done outside div")
    `ASSERT_IMPLIES(a_ok_from_search, ok_done, $past(state_reg) == S_SEARCH, "ok without search")
    `ASSERT_IMPLIES(a_div_mod_busy, state_reg == S_DIV, mod_stat.busy || mod_stat.done, "mod idle")

endmodule
